// ----- design/fsjc_pkg.sv -----
// ----------------------------------------------------------------------------
// fsjc_pkg
// Shared types and constants of the focus stepper jog controller: key windows,
// command and direction codes, register indexes and the result record.
// ----------------------------------------------------------------------------
package fsjc_pkg;

	localparam int unsigned AdcW   = 10;
	localparam int unsigned StepsW = 16;
	localparam int unsigned PhaseW = 3;
	localparam int unsigned PosW   = 8;
	localparam int unsigned CfgW   = 16;

	// key ladder windows, inclusive code bounds
	localparam logic [AdcW-1:0] AGING_LO = 10'd559;
	localparam logic [AdcW-1:0] AGING_HI = 10'd626;
	localparam logic [AdcW-1:0] STOP_LO  = 10'd900;
	localparam logic [AdcW-1:0] STOP_HI  = 10'd960;
	localparam logic [AdcW-1:0] REV_LO   = 10'd714;
	localparam logic [AdcW-1:0] REV_HI   = 10'd774;
	localparam logic [AdcW-1:0] FWD_LO   = 10'd807;
	localparam logic [AdcW-1:0] FWD_HI   = 10'd867;

	localparam logic [StepsW-1:0] JOG_STEPS_RST    = 16'd20;
	localparam logic [StepsW-1:0] AGING_PERIOD_RST = 16'd3600;

	localparam logic ACT_KEY  = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	localparam logic CFG_JOG_STEPS    = 1'b0;
	localparam logic CFG_AGING_PERIOD = 1'b1;

	typedef enum logic [1:0] {
		DIR_STOP = 2'd0,
		DIR_FWD  = 2'd1,
		DIR_REV  = 2'd2
	} dir_t;

	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_AGING = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_REV   = 3'd3,
		CMD_FWD   = 3'd4
	} key_cmd_t;

	typedef struct packed {
		logic              step_valid;
		logic [PhaseW-1:0] phase;
		dir_t              direction;
		logic [PosW-1:0]   position;
		logic              done_res;
		logic              aging_active;
	} res_t;

endpackage

// ----- design/fsjc_key_dec.sv -----
// ----------------------------------------------------------------------------
// fsjc_key_dec
// Decodes a key ladder ADC code into a jog command by fixed code windows.
// ----------------------------------------------------------------------------
module fsjc_key_dec (
	input  logic [fsjc_pkg::AdcW-1:0] adc_code,
	output fsjc_pkg::key_cmd_t        cmd
);

	always_comb begin
		if (adc_code >= fsjc_pkg::AGING_LO && adc_code <= fsjc_pkg::AGING_HI) begin
			cmd = fsjc_pkg::CMD_AGING;
		end else if (adc_code >= fsjc_pkg::STOP_LO && adc_code <= fsjc_pkg::STOP_HI) begin
			cmd = fsjc_pkg::CMD_STOP;
		end else if (adc_code >= fsjc_pkg::REV_LO && adc_code <= fsjc_pkg::REV_HI) begin
			cmd = fsjc_pkg::CMD_REV;
		end else if (adc_code >= fsjc_pkg::FWD_LO && adc_code <= fsjc_pkg::FWD_HI) begin
			cmd = fsjc_pkg::CMD_FWD;
		end else begin
			cmd = fsjc_pkg::CMD_NONE;
		end
	end

endmodule

// ----- design/fsjc_core.sv -----
// ----------------------------------------------------------------------------
// fsjc_core
// Motion state and configuration registers; computes the next state and the
// result record for one key sample or tick, and commits it on advance.
// ----------------------------------------------------------------------------
module fsjc_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [fsjc_pkg::CfgW-1:0]      cfg_wdata,
	input  logic                           adv,
	input  logic                           action,
	input  fsjc_pkg::key_cmd_t             cmd,
	output fsjc_pkg::res_t                 res
);

	logic [fsjc_pkg::StepsW-1:0] jog_steps_q;
	logic [fsjc_pkg::StepsW-1:0] aging_period_q;

	logic [fsjc_pkg::PhaseW-1:0] phase_q, phase_d;
	fsjc_pkg::dir_t              dir_q, dir_d;
	logic [fsjc_pkg::StepsW-1:0] steps_q, steps_d;
	logic [fsjc_pkg::PosW-1:0]   pos_q, pos_d;
	logic                        done_q, done_d;
	logic                        aging_q, aging_d;
	logic [fsjc_pkg::StepsW-1:0] ticks_q, ticks_d;
	logic                        step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jog_steps_q    <= fsjc_pkg::JOG_STEPS_RST;
			aging_period_q <= fsjc_pkg::AGING_PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				fsjc_pkg::CFG_JOG_STEPS:    jog_steps_q    <= cfg_wdata;
				fsjc_pkg::CFG_AGING_PERIOD: aging_period_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		phase_d = phase_q;
		dir_d   = dir_q;
		steps_d = steps_q;
		pos_d   = pos_q;
		done_d  = done_q;
		aging_d = aging_q;
		ticks_d = ticks_q;
		step    = 1'b0;
		if (action == fsjc_pkg::ACT_KEY) begin
			case (cmd)
				fsjc_pkg::CMD_AGING: aging_d = 1'b1;
				fsjc_pkg::CMD_STOP: begin
					dir_d   = fsjc_pkg::DIR_STOP;
					aging_d = 1'b0;
				end
				fsjc_pkg::CMD_REV: begin
					dir_d   = fsjc_pkg::DIR_REV;
					steps_d = jog_steps_q;
				end
				fsjc_pkg::CMD_FWD: begin
					dir_d   = fsjc_pkg::DIR_FWD;
					steps_d = jog_steps_q;
				end
				default: ;
			endcase
		end else if (aging_q) begin
			step = 1'b1;
			if (ticks_q < aging_period_q) begin
				ticks_d = ticks_q + 16'd1;
			end else begin
				ticks_d = '0;
				dir_d   = (dir_q == fsjc_pkg::DIR_FWD) ? fsjc_pkg::DIR_REV : fsjc_pkg::DIR_FWD;
			end
		end else if (steps_q != '0) begin
			step    = 1'b1;
			steps_d = steps_q - 16'd1;
			if (steps_q == 16'd1) begin
				done_d = 1'b1;
			end
		end
		if (step) begin
			phase_d = phase_q + 3'd1;
			if (dir_d == fsjc_pkg::DIR_FWD) begin
				pos_d = pos_q + 8'd1;
			end else if (dir_d == fsjc_pkg::DIR_REV) begin
				pos_d = pos_q - 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			dir_q   <= fsjc_pkg::DIR_STOP;
			steps_q <= '0;
			pos_q   <= '0;
			done_q  <= 1'b0;
			aging_q <= 1'b0;
			ticks_q <= '0;
		end else if (adv) begin
			phase_q <= phase_d;
			dir_q   <= dir_d;
			steps_q <= steps_d;
			pos_q   <= pos_d;
			done_q  <= done_d;
			aging_q <= aging_d;
			ticks_q <= ticks_d;
		end
	end

	assign res = '{
		step_valid:   step,
		phase:        phase_d,
		direction:    dir_d,
		position:     pos_d,
		done_res:     done_d,
		aging_active: aging_d
	};

`ifndef ASSERT_OFF
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> done_q)
		else $error("done flag cleared");

	a_hold_no_step: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !step |=> phase_q == $past(phase_q) && pos_q == $past(pos_q))
		else $error("phase or position moved without a step");

	a_phase_step: assert property (@(posedge clk) disable iff (!arst_n)
		adv && step |=> phase_q == 3'($past(phase_q) + 3'd1))
		else $error("phase did not advance by one");

	a_key_no_step: assert property (@(posedge clk) disable iff (!arst_n)
		action == fsjc_pkg::ACT_KEY |-> !step)
		else $error("step on a key sample");

	a_countdown: assert property (@(posedge clk) disable iff (!arst_n)
		adv && step && !aging_q |=> steps_q == 16'($past(steps_q) - 16'd1))
		else $error("jog countdown mismatch");
`endif

endmodule

// ----- design/focus_stepper_jog_controller.sv -----
// ----------------------------------------------------------------------------
// focus_stepper_jog_controller
// Lens focus stepper controller: decodes key ladder samples into jog, stop and
// aging commands and steps the 8-phase drive, position and jog countdown.
//
// channel | direction | handshake          | payload
// in      | sink      | in_valid/in_ready  | action, adc_code
// out     | source    | out_valid/out_ready| step_valid, phase, direction,
//         |           |                    | position, done_res, aging_active
// cfg     | sink      | cfg_we             | cfg_index, cfg_wdata
//
// one item per cycle sustained while out_ready is high; each item passes through
// the input register and then the result register
// the motion state is committed as the item moves into the result register
// a stalled output holds its result; one more item waits in the input register
// reset clears the valid flags and the motion state; config registers reset to 20 and 3600
// ----------------------------------------------------------------------------
module focus_stepper_jog_controller (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           action,
	input  logic [fsjc_pkg::AdcW-1:0]      adc_code,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           step_valid,
	output logic [fsjc_pkg::PhaseW-1:0]    phase,
	output logic [1:0]                     direction,
	output logic [fsjc_pkg::PosW-1:0]      position,
	output logic                           done_res,
	output logic                           aging_active,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [fsjc_pkg::CfgW-1:0]      cfg_wdata
);

	logic                         valid_s1;
	logic                         action_s1;
	logic [fsjc_pkg::AdcW-1:0]    adc_code_s1;
	logic                         valid_s2;
	fsjc_pkg::res_t               res_s2;
	fsjc_pkg::res_t               res;
	fsjc_pkg::key_cmd_t           cmd;
	logic                         adv;

	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			action_s1   <= action;
			adc_code_s1 <= adc_code;
		end
	end

	fsjc_key_dec u_key_dec (
		.adc_code (adc_code_s1),
		.cmd      (cmd)
	);

	fsjc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.adv       (adv),
		.action    (action_s1),
		.cmd       (cmd),
		.res       (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign step_valid   = res_s2.step_valid;
	assign phase        = res_s2.phase;
	assign direction    = res_s2.direction;
	assign position     = res_s2.position;
	assign done_res     = res_s2.done_res;
	assign aging_active = res_s2.aging_active;

endmodule
